// ===== design/laplacian_edge_stencil_defines.svh =====
// Assertion macros shared by the checkers of the Laplacian edge stencil.
// Included by bare file name; needs nothing else.
`ifndef LAPLACIAN_EDGE_STENCIL_DEFINES_SVH
`define LAPLACIAN_EDGE_STENCIL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LES_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("les_checker: implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define LES_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("les_checker: next-cycle implication violated");

`endif

// ===== design/les_pkg.sv =====
// Shared types and constants of the Laplacian edge stencil.
// No dependencies; compile first.
`timescale 1ns / 1ps

package les_pkg;

    localparam int WIDTH_W      = 11;   // image_width register
    localparam int HEIGHT_W     = 13;   // image_height register
    localparam int ROW_W        = 13;   // row counter, holds up to MAX_HEIGHT + 1
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;   // widest register
    localparam int EDGE_W       = 11;
    localparam int EDGE_MAX     = 1023;
    localparam int EDGE_MIN     = -1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

// ===== design/les_stream_if.sv =====
// Valid/ready stream interfaces for the pixel input and the edge result output.
// Depends on les_pkg.
`timescale 1ns / 1ps

interface pixel_stream_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface edge_stream_if;
    import les_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [EDGE_W-1:0] edge_value;
    logic                     last_in_row;
    logic                     last_in_frame;

    modport source (output valid, output edge_value, output last_in_row,
                    output last_in_frame, input ready);
    modport sink   (input valid, input edge_value, input last_in_row,
                    input last_in_frame, output ready);
endinterface

// ===== design/les_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module les_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/laplacian_edge_stencil.sv =====
// Streaming 5-point Laplacian edge filter: top level with line buffers and output stage.
// Depends on les_pkg, les_stream_if (pixel_stream_if, edge_stream_if) and les_ram.
`timescale 1ns / 1ps

// The block takes one pixel beat per clock in raster order: a top boundary row,
// image_height image rows, then a bottom boundary row, all image_width wide. For
// each image pixel it returns up + down + left + right - 4*centre as an 11-bit
// two's complement value, saturated; neighbors past the row ends read as zero.
// The result for a pixel leaves in the cycle after the pixel directly below it is
// accepted, so boundary rows give no results and the first two rows of a frame
// only fill the line buffers. Throughput is one pixel per cycle unless stalled:
// the two line buffers are RAMs with one registered read port each, and the read
// for the next column's right-hand neighbor is issued in advance, every cycle,
// so the data is already waiting when the next pixel arrives. The output register
// takes a new result in the same cycle its old one is taken. The line buffers
// have no reset and need no clearing pass; no result reads an entry that the
// current frame has not written. A write to either configuration register
// restarts the frame at once; write registers only while the block is idle.
module laplacian_edge_stencil #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pixel_stream_if.sink                    pixel_in,
    edge_stream_if.source                   edge_out,
    input  logic                            cfg_we,
    input  logic [les_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [les_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import les_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);                  // column / address bits
    localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
    localparam int SW = PIXEL_BITS + 3;                     // raw stencil sum
    localparam int XW = (SW > EDGE_W) ? SW : EDGE_W;        // sum before clamping
    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam logic [CW-1:0]    RST_LAST_COL = CW'(RST_W - 1);
    localparam logic [ROW_W-1:0] RST_LAST_ROW = ROW_W'(RESET_HEIGHT + 1);
    localparam logic signed [XW-1:0] SAT_HI = XW'(EDGE_MAX);
    localparam logic signed [XW-1:0] SAT_LO = XW'(EDGE_MIN);

    // Frame position and derived geometry.
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    last_col_reg, last_col_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic             col_last, row_last, produce;
    logic             cfg_hit;
    logic [EW-1:0]    width_val;
    logic [HEIGHT_W-1:0] height_val;

    // Line buffer access.
    logic                  accept;
    logic [PIXEL_BITS-1:0] pix;
    logic [CW-1:0]         rd_addr;
    logic [PIXEL_BITS-1:0] new_q, old_q;
    logic [PIXEL_BITS-1:0] look_new, look_old;
    logic                  byp_reg;
    logic [PIXEL_BITS-1:0] byp_new_reg, byp_old_reg;
    logic [PIXEL_BITS-1:0] carry_new_reg, carry_old_reg;
    logic [PIXEL_BITS-1:0] first_new_reg, first_old_reg;
    logic [PIXEL_BITS-1:0] left_reg;

    // Stencil operands and sum.
    logic [PIXEL_BITS-1:0] centre, up, left, right;
    logic signed [SW-1:0]  sum;
    logic signed [XW-1:0]  sum_x, sat;

    // Output stage.
    logic                     out_valid_reg, out_valid_next;
    logic signed [EDGE_W-1:0] edge_value_reg;
    logic                     last_in_row_reg, last_in_frame_reg;

    assign pix    = pixel_in.pixel_value;
    assign accept = pixel_in.valid && pixel_in.ready;

    // Accept while the output register is empty or being drained this cycle.
    assign pixel_in.ready = !out_valid_reg || edge_out.ready;

    assign col_last = (col_reg == last_col_reg);
    assign row_last = (row_reg == last_row_reg);
    assign produce  = (row_reg > ROW_W'(1));     // rows above hold only boundary/history

    assign cfg_hit = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                                (cfg_index == REG_IMAGE_HEIGHT));

    // Geometry from a register write: clamp to the supported range.
    assign width_val  = EW'(cfg_data[WIDTH_W-1:0]);
    assign height_val = cfg_data[HEIGHT_W-1:0];

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (width_val == '0)
                    begin
                        last_col_next = '0;
                    end
                    else if (width_val > EW'(MAX_WIDTH))
                    begin
                        last_col_next = CW'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        last_col_next = CW'(width_val - 1'b1);
                    end
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (height_val == '0)
                    begin
                        last_row_next = ROW_W'(2);
                    end
                    else if (height_val > HEIGHT_W'(MAX_HEIGHT))
                    begin
                        last_row_next = ROW_W'(MAX_HEIGHT + 1);
                    end
                    else
                    begin
                        last_row_next = ROW_W'(height_val + 1'b1);
                    end
                end
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
        end
    end

    // Advance the raster position; a register write restarts the frame.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Prefetch the column right of the next position, every cycle, so that the
    // data is current no matter how long the input stalls.
    assign rd_addr = (col_next == CW'(MAX_WIDTH - 1)) ? '0 : col_next + 1'b1;

    les_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_newer_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pix),
        .raddr (rd_addr),
        .rdata (new_q)
    );

    // The older row takes over the entry the newer row gives up.
    les_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (centre),
        .raddr (rd_addr),
        .rdata (old_q)
    );

    // A read that hits the entry written in the same cycle (two-wide rows)
    // returns stale data: forward the written values instead.
    assign look_new = byp_reg ? byp_new_reg : new_q;
    assign look_old = byp_reg ? byp_old_reg : old_q;

    // Column zero is not taken from the prefetch: it lives in its own pair of registers.
    assign centre = (col_reg == '0) ? first_new_reg : carry_new_reg;
    assign up     = (col_reg == '0) ? first_old_reg : carry_old_reg;
    assign left   = (col_reg == '0) ? '0 : left_reg;
    assign right  = col_last ? '0 : look_new;

    assign sum = $signed(SW'(up)) + $signed(SW'(pix)) + $signed(SW'(left))
               + $signed(SW'(right)) - ($signed(SW'(centre)) <<< 2);
    assign sum_x = XW'(sum);

    always_comb
    begin
        if (sum_x > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (sum_x < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = sum_x;
        end
    end

    // Output register: hold until taken, reload on an accepted pixel.
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = produce;
        end
        else
        begin
            out_valid_next = out_valid_reg && !edge_out.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            last_col_reg  <= RST_LAST_COL;
            last_row_reg  <= RST_LAST_ROW;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            last_col_reg  <= last_col_next;
            last_row_reg  <= last_row_next;
            out_valid_reg <= out_valid_next;
            byp_reg       <= accept && (col_reg == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_new_reg <= pix;
        byp_old_reg <= centre;
        if (accept)
        begin
            carry_new_reg <= look_new;
            carry_old_reg <= look_old;
            left_reg      <= centre;
            if (col_reg == '0)
            begin
                first_new_reg <= pix;
                first_old_reg <= first_new_reg;
            end
            if (produce)
            begin
                edge_value_reg    <= sat[EDGE_W-1:0];
                last_in_row_reg   <= col_last;
                last_in_frame_reg <= col_last && row_last;
            end
        end
    end

    assign edge_out.valid         = out_valid_reg;
    assign edge_out.edge_value    = edge_value_reg;
    assign edge_out.last_in_row   = last_in_row_reg;
    assign edge_out.last_in_frame = last_in_frame_reg;

endmodule

// ===== design/les_checker.sv =====
// Port-level checker for the Laplacian edge stencil, bound to the top level.
// Depends on les_pkg and laplacian_edge_stencil_defines.svh.
`timescale 1ns / 1ps
`include "laplacian_edge_stencil_defines.svh"

module les_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [les_pkg::EDGE_W-1:0] edge_value,
    input logic                             last_in_row,
    input logic                             last_in_frame
);
    import les_pkg::*;

    // A stalled result beat holds.
    `LES_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(edge_value) && $stable(last_in_row) && $stable(last_in_frame))

    // Every new result beat follows an accepted pixel in the cycle before.
    `LES_ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid && !$past(out_valid && !out_ready), $past(in_valid && in_ready))

    // The end of the image is also the end of a row.
    `LES_ASSERT_IMP(a_frame_end_row_end, clk, rst_n, out_valid && last_in_frame, last_in_row)

    // An empty output stage never blocks the input.
    `LES_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

endmodule

bind laplacian_edge_stencil les_checker u_les_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixel_in.valid),
    .in_ready      (pixel_in.ready),
    .out_valid     (edge_out.valid),
    .out_ready     (edge_out.ready),
    .edge_value    (edge_out.edge_value),
    .last_in_row   (edge_out.last_in_row),
    .last_in_frame (edge_out.last_in_frame)
);
